// ===== hdl/plc_pkg.sv =====
// Shared codes, widths and cell control type for the positional character list.
package plc_pkg;

  localparam int DATA_W = 8;
  localparam int POS_W  = 7;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_GET = 2'd1;
  localparam logic [OP_W-1:0] OP_DEL = 2'd2;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic shift_right;   // add: every cell takes its left neighbor, the head cell the input byte
    logic shift_left;    // delete: cells at or after the hit take their right neighbor
  } plc_cell_ctl_t;

endpackage

// ===== hdl/positional_char_list.sv =====
// Positional character list: a chain of byte cells with front insert, get and delete.
// The result beat is registered and appears in the cycle after the input beat is accepted.
// Throughput: one operation per cycle while the sink takes results; every cell shifts in parallel in that cycle.
// A new beat is taken while the held result is being taken by the sink.
// Reset clears the entry count and the result valid; cell contents stay undefined
// until written, and no cell beyond the count is ever read.
module positional_char_list #(
  parameter int CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [plc_pkg::OP_W-1:0]      in_operation,
  input  logic [plc_pkg::DATA_W-1:0]    in_value,
  input  logic [plc_pkg::POS_W-1:0]     in_position,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [plc_pkg::DATA_W-1:0]    out_read_value,
  output logic [plc_pkg::ST_W-1:0]      out_status,
  output logic [plc_pkg::POS_W-1:0]     out_count
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > plc_pkg::POS_W) ? CW : plc_pkg::POS_W;

  logic [CW-1:0]                 count_r;
  logic [CW-1:0]                 count_nxt;
  logic                          out_valid_r;
  logic [plc_pkg::DATA_W-1:0]    out_read_value_r;
  logic [plc_pkg::ST_W-1:0]      out_status_r;
  logic [plc_pkg::POS_W-1:0]     out_count_r;

  logic                          fire;
  logic                          add_ok;
  logic                          del_ok;
  logic [plc_pkg::ST_W-1:0]      status;
  logic [plc_pkg::DATA_W-1:0]    rd_value;
  logic [plc_pkg::POS_W-1:0]     pos_m1;
  logic                          is_full;
  logic                          is_empty;
  logic                          pos_bad;
  plc_pkg::plc_cell_ctl_t        ctl;

  logic [plc_pkg::DATA_W-1:0]    cell_data [CAPACITY];
  logic [plc_pkg::DATA_W-1:0]    cell_rd   [CAPACITY];

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign pos_m1   = in_position - 7'd1;

  assign is_full  = (count_r >= CW'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign pos_bad  = (in_position == '0) || (CMPW'(in_position) > CMPW'(count_r));

  always_comb begin
    status = plc_pkg::ST_OK;
    add_ok = 1'b0;
    del_ok = 1'b0;
    unique case (in_operation)
      plc_pkg::OP_ADD: begin
        if (is_full) begin
          status = plc_pkg::ST_FULL;
        end else begin
          add_ok = 1'b1;
        end
      end
      plc_pkg::OP_GET, plc_pkg::OP_DEL: begin
        if (is_empty) begin
          status = plc_pkg::ST_EMPTY;
        end else if (pos_bad) begin
          status = plc_pkg::ST_BADPOS;
        end else begin
          del_ok = (in_operation == plc_pkg::OP_DEL);
        end
      end
      default: begin
        status = plc_pkg::ST_OK;
      end
    endcase
  end

  assign ctl.shift_right = fire && add_ok;
  assign ctl.shift_left  = fire && del_ok;

  // Only the addressed cell drives a nonzero byte, so OR-ing picks it out.
  always_comb begin
    rd_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_value = rd_value | cell_rd[i];
    end
    if ((status != plc_pkg::ST_OK) ||
        !((in_operation == plc_pkg::OP_GET) || (in_operation == plc_pkg::OP_DEL))) begin
      rd_value = '0;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.shift_right) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.shift_left) begin
      count_nxt = count_r - 1'b1;
    end
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [plc_pkg::DATA_W-1:0] left_src;
      logic [plc_pkg::DATA_W-1:0] right_src;
      if (g == 0) begin : g_head
        assign left_src = in_value;
      end else begin : g_mid
        assign left_src = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
        assign right_src = cell_data[g];
      end else begin : g_body
        assign right_src = cell_data[g+1];
      end
      plc_cell #(
        .IDX (g)
      ) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .pos_m1   (pos_m1),
        .left_in  (left_src),
        .right_in (right_src),
        .data_out (cell_data[g]),
        .rd_out   (cell_rd[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_read_value_r <= rd_value;
      out_status_r     <= status;
      out_count_r      <= plc_pkg::POS_W'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;

endmodule

// ===== hdl/plc_cell.sv =====
// One storage cell of the list: holds a byte and shifts with its neighbors.
module plc_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  plc_pkg::plc_cell_ctl_t        ctl,
  input  logic [plc_pkg::POS_W-1:0]     pos_m1,
  input  logic [plc_pkg::DATA_W-1:0]    left_in,
  input  logic [plc_pkg::DATA_W-1:0]    right_in,
  output logic [plc_pkg::DATA_W-1:0]    data_out,
  output logic [plc_pkg::DATA_W-1:0]    rd_out
);

  logic [plc_pkg::DATA_W-1:0] data_r;
  logic [plc_pkg::DATA_W-1:0] data_nxt;
  logic                       sel;
  logic                       at_or_after;

  assign sel         = (int'(pos_m1) == IDX);
  assign at_or_after = (IDX >= int'(pos_m1));

  always_comb begin
    data_nxt = data_r;
    if (ctl.shift_right) begin
      data_nxt = left_in;
    end else if (ctl.shift_left && at_or_after) begin
      data_nxt = right_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;
  assign rd_out   = sel ? data_r : '0;

endmodule

// ===== dv/tb.sv =====
// Testbench for positional_char_list: directed table plus random op mix checked against a shadow list.
`timescale 1ns / 1ps

module tb;

  localparam int CLK_PERIOD    = 4;
  localparam int LIST_DEPTH    = 64;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int TAIL_ITEMS    = 150;
  localparam int HOLD_OFF_CYC  = 300;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int DIR_ROWS      = 26;

  // Operation code 3 does nothing but report the count.
  localparam logic [plc_pkg::OP_W-1:0] OP_NOP = 2'd3;

  typedef struct packed {
    logic [plc_pkg::DATA_W-1:0] read_value;
    logic [plc_pkg::ST_W-1:0]   status;
    logic [plc_pkg::POS_W-1:0]  count;
  } list_reply_t;

  typedef struct packed {
    logic [plc_pkg::OP_W-1:0]   op;
    logic [plc_pkg::DATA_W-1:0] value;
    logic [plc_pkg::POS_W-1:0]  position;
    logic [7:0]                 reps;
    logic                       fixed_reply;
    list_reply_t                reply;
  } dir_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [plc_pkg::OP_W-1:0]     in_operation = '0;
  logic [plc_pkg::DATA_W-1:0]   in_value = '0;
  logic [plc_pkg::POS_W-1:0]    in_position = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [plc_pkg::DATA_W-1:0]   out_read_value;
  logic [plc_pkg::ST_W-1:0]     out_status;
  logic [plc_pkg::POS_W-1:0]    out_count;

  // shadow copy of the list contents
  logic [plc_pkg::DATA_W-1:0]   held_bytes [LIST_DEPTH];
  int                           held_count = 0;
  list_reply_t                  awaited_replies [$];
  int                           mismatches = 0;
  bit                           hold_off_req = 1'b0;
  bit                           steady_tail = 1'b0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{plc_pkg::OP_GET, 8'h00, 7'd1,   8'd1,  1'b1, '{8'h00, plc_pkg::ST_EMPTY,  7'd0}},
    '{plc_pkg::OP_DEL, 8'h00, 7'd1,   8'd1,  1'b1, '{8'h00, plc_pkg::ST_EMPTY,  7'd0}},
    '{plc_pkg::OP_DEL, 8'hFF, 7'd0,   8'd1,  1'b1, '{8'h00, plc_pkg::ST_EMPTY,  7'd0}},
    '{OP_NOP,          8'hFF, 7'd127, 8'd1,  1'b1, '{8'h00, plc_pkg::ST_OK,     7'd0}},
    '{plc_pkg::OP_ADD, 8'hFF, 7'd0,   8'd1,  1'b1, '{8'h00, plc_pkg::ST_OK,     7'd1}},
    '{plc_pkg::OP_GET, 8'h00, 7'd1,   8'd1,  1'b1, '{8'hFF, plc_pkg::ST_OK,     7'd1}},
    '{plc_pkg::OP_GET, 8'h00, 7'd0,   8'd1,  1'b1, '{8'h00, plc_pkg::ST_BADPOS, 7'd1}},
    '{plc_pkg::OP_GET, 8'h00, 7'd2,   8'd1,  1'b1, '{8'h00, plc_pkg::ST_BADPOS, 7'd1}},
    '{plc_pkg::OP_DEL, 8'h00, 7'd127, 8'd1,  1'b1, '{8'h00, plc_pkg::ST_BADPOS, 7'd1}},
    '{plc_pkg::OP_ADD, 8'h00, 7'd127, 8'd1,  1'b1, '{8'h00, plc_pkg::ST_OK,     7'd2}},
    '{plc_pkg::OP_ADD, 8'h5A, 7'd0,   8'd1,  1'b0, '0},
    '{plc_pkg::OP_GET, 8'h00, 7'd3,   8'd1,  1'b0, '0},
    '{plc_pkg::OP_DEL, 8'h00, 7'd2,   8'd1,  1'b0, '0},
    '{OP_NOP,          8'h00, 7'd0,   8'd1,  1'b0, '0},
    '{plc_pkg::OP_DEL, 8'h00, 7'd1,   8'd1,  1'b0, '0},
    '{plc_pkg::OP_DEL, 8'h00, 7'd1,   8'd1,  1'b0, '0},
    '{plc_pkg::OP_DEL, 8'h00, 7'd1,   8'd1,  1'b1, '{8'h00, plc_pkg::ST_EMPTY,  7'd0}},
    '{plc_pkg::OP_ADD, 8'h80, 7'd0,   8'd64, 1'b0, '0},
    '{plc_pkg::OP_ADD, 8'h11, 7'd0,   8'd1,  1'b1, '{8'h00, plc_pkg::ST_FULL,   7'd64}},
    '{plc_pkg::OP_GET, 8'h00, 7'd64,  8'd1,  1'b0, '0},
    '{plc_pkg::OP_GET, 8'h00, 7'd65,  8'd1,  1'b1, '{8'h00, plc_pkg::ST_BADPOS, 7'd64}},
    '{plc_pkg::OP_DEL, 8'h00, 7'd64,  8'd1,  1'b0, '0},
    '{plc_pkg::OP_ADD, 8'hAA, 7'd0,   8'd1,  1'b0, '0},
    '{plc_pkg::OP_DEL, 8'h00, 7'd1,   8'd1,  1'b0, '0},
    '{plc_pkg::OP_GET, 8'h00, 7'd127, 8'd1,  1'b1, '{8'h00, plc_pkg::ST_BADPOS, 7'd63}},
    '{OP_NOP,          8'h3C, 7'd5,   8'd1,  1'b0, '0}
  };

  positional_char_list #(.CAPACITY(LIST_DEPTH)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_count      (out_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Applies one operation to the shadow list and returns the reply it should produce.
  function automatic list_reply_t apply_list_op(logic [plc_pkg::OP_W-1:0] op,
                                                logic [plc_pkg::DATA_W-1:0] val,
                                                logic [plc_pkg::POS_W-1:0] pos);
    list_reply_t r;
    int i;
    r = '0;
    r.status = plc_pkg::ST_OK;
    case (op)
      plc_pkg::OP_ADD: begin
        if (held_count >= LIST_DEPTH) begin
          r.status = plc_pkg::ST_FULL;
        end else begin
          for (i = held_count; i > 0; i--) held_bytes[i] = held_bytes[i-1];
          held_bytes[0] = val;
          held_count++;
        end
      end
      plc_pkg::OP_GET, plc_pkg::OP_DEL: begin
        // empty wins over a bad position
        if (held_count == 0) begin
          r.status = plc_pkg::ST_EMPTY;
        end else if (pos == 0 || pos > held_count) begin
          r.status = plc_pkg::ST_BADPOS;
        end else begin
          r.read_value = held_bytes[pos-1];
          if (op == plc_pkg::OP_DEL) begin
            for (i = pos - 1; i + 1 < held_count; i++) held_bytes[i] = held_bytes[i+1];
            held_count--;
          end
        end
      end
      default: ;
    endcase
    r.count = held_count[plc_pkg::POS_W-1:0];
    return r;
  endfunction

  // Mostly legal positions, with zero, the last entry and out-of-range mixed in.
  function automatic logic [plc_pkg::POS_W-1:0] pick_position(int cnt);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return plc_pkg::POS_W'($urandom_range(cnt + 1, 127));
      2: return plc_pkg::POS_W'((cnt > 0) ? cnt : 127);
      default: return (cnt == 0) ? plc_pkg::POS_W'($urandom_range(0, 127))
                                 : plc_pkg::POS_W'($urandom_range(1, cnt));
    endcase
  endfunction

  task automatic send_op(logic [plc_pkg::OP_W-1:0] op, logic [plc_pkg::DATA_W-1:0] val,
                         logic [plc_pkg::POS_W-1:0] pos, bit use_fixed, list_reply_t fixed);
    list_reply_t predicted;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= val;
    in_position  <= pos;
    do @(posedge clk); while (!in_ready);
    predicted = apply_list_op(op, val, pos);
    awaited_replies.push_back(use_fixed ? fixed : predicted);
  endtask

  task automatic pause_source(int n);
    @(negedge clk);
    in_valid     <= 1'b0;
    in_operation <= 2'($urandom);
    in_value     <= 8'($urandom);
    in_position  <= 7'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  initial begin : stimulus
    int row, k, issued, phase_kind, phase_left, r, guard;
    bit gappy;
    logic [plc_pkg::OP_W-1:0] op;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (row = 0; row < DIR_ROWS; row++) begin
      for (k = 0; k < dir_rows[row].reps; k++) begin
        if ($urandom_range(0, 3) == 0) pause_source($urandom_range(1, 14));
        send_op(dir_rows[row].op, dir_rows[row].value + plc_pkg::DATA_W'(k),
                dir_rows[row].position, dir_rows[row].fixed_reply, dir_rows[row].reply);
      end
    end

    // sink goes quiet for a long while as random traffic starts, so the input backs up
    hold_off_req = 1'b1;
    issued = 0;
    phase_left = 0;
    phase_kind = 0;
    gappy = 1'b0;
    while (issued < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase_kind = $urandom_range(0, 2);
        phase_left = $urandom_range(30, 120);
        gappy = ($urandom_range(0, 2) != 0);
      end
      if (issued >= RANDOM_ITEMS - TAIL_ITEMS) steady_tail = 1'b1;
      if (!steady_tail && gappy && $urandom_range(0, 4) == 0) pause_source($urandom_range(1, 14));
      r = $urandom_range(0, 99);
      case (phase_kind)
        0:       op = (r < 70) ? plc_pkg::OP_ADD : (r < 85) ? plc_pkg::OP_GET :
                      (r < 97) ? plc_pkg::OP_DEL : OP_NOP;
        1:       op = (r < 15) ? plc_pkg::OP_ADD : (r < 35) ? plc_pkg::OP_GET :
                      (r < 97) ? plc_pkg::OP_DEL : OP_NOP;
        default: op = (r < 40) ? plc_pkg::OP_ADD : (r < 65) ? plc_pkg::OP_GET :
                      (r < 95) ? plc_pkg::OP_DEL : OP_NOP;
      endcase
      send_op(op, 8'($urandom), pick_position(held_count), 1'b0, '0);
      issued++;
      phase_left--;
    end
    @(negedge clk);
    in_valid <= 1'b0;

    guard = 0;
    while (awaited_replies.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (guard >= DRAIN_LIMIT) begin
      $display("%0t: %0d replies never arrived", $time, awaited_replies.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      repeat (8) @(posedge clk);
      if (mismatches == 0 && awaited_replies.size() == 0) begin
        $display("SCOREBOARD CLEAN");
      end else begin
        $display("SCOREBOARD MISMATCH");
      end
      $finish;
    end
  end

  initial begin : sink_pacing
    int tick;
    bit calm;
    tick = 0;
    calm = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      tick++;
      if (tick % 64 == 0) calm = ($urandom_range(0, 2) == 0);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYC) @(negedge clk);
        out_ready <= 1'b1;
      end else if (!steady_tail && !calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : reply_check
    list_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected beat rd=%0d st=%0d cnt=%0d", $time, out_read_value,
                 out_status, out_count);
        mismatches++;
      end else begin
        want = awaited_replies.pop_front();
        if (out_read_value !== want.read_value) begin
          $display("%0t: read_value expected %0d actual %0d", $time, want.read_value,
                   out_read_value);
          mismatches++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          mismatches++;
        end
        if (out_count !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count, out_count);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("%0t: run timed out", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
